@@ src/ppre_pkg.sv @@
// Shared types, command and raster-op codes, and the byte combine function.
package ppre_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int COORD_W = 13;
    localparam int COLOR_W = 4;
    localparam int ROP_W   = 2;
    localparam int LB_W    = 11;
    localparam int WORD_W  = 32;
    // Widest byte offset: (8191 + 8191) * 2047 + 1023 fits in 26 bits
    localparam int OFF_W   = 26;
    localparam int PROD_W  = 25;

    localparam logic [LB_W-1:0] LINE_BYTES_RESET = 11'd80;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_HSPAN = 2'd2,
        CMD_VSPAN = 2'd3
    } cmd_t;

    typedef enum logic [ROP_W-1:0] {
        ROP_WRITE = 2'd0,
        ROP_XOR   = 2'd1,
        ROP_OR    = 2'd2,
        ROP_AND   = 2'd3
    } rop_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_RD,
        ST_WR
    } state_t;

    // Combine the color bits into the masked pixels of all four plane bytes
    function automatic logic [WORD_W-1:0] apply_rop(
        input logic [WORD_W-1:0]  word,
        input logic [COLOR_W-1:0] color,
        input rop_t               op,
        input logic [7:0]         mask
    );
        logic [WORD_W-1:0] res;
        logic [7:0]        b;
        res = word;
        for (int n = 0; n < COLOR_W; n++)
        begin
            b = word[8*n +: 8];
            case (op)
                ROP_WRITE: b = color[n] ? (b | mask) : (b & ~mask);
                ROP_XOR:   b = color[n] ? (b ^ mask) : b;
                ROP_OR:    b = color[n] ? (b | mask) : b;
                ROP_AND:   b = color[n] ? b : (b & ~mask);
                default:   b = b;
            endcase
            res[8*n +: 8] = b;
        end
        return res;
    endfunction

endpackage

@@ src/ppre_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
module ppre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write when we is high; the read data is registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ src/planar_pixel_raster_engine.sv @@
// Top level: four-plane 16-color frame store with pixel and span raster ops.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------------
//  request   | start / busy          | command, x, y, color, raster_op, length
//  result    | done (one-cycle)      | pixel_color, status
//  config    | psel penable pwrite   | paddr, pwdata, prdata (line_bytes), pready
//
// A pixel read or draw runs ST_MUL, ST_CHECK, ST_RD and ST_WR after accept; a
// horizontal span repeats ST_RD and ST_WR per plane byte touched, a vertical
// span per row. The single-port plane RAM sets this: each byte is read in ST_RD
// and written back in the cycle after, so overlapping bytes never need forwarding.
// After reset a clearing pass zeroes the store while busy stays high. The result
// strobe is not held off; busy drops in the cycle the result appears.
module planar_pixel_raster_engine
    import ppre_pkg::*;
#(
    parameter int PLANE_BYTES = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    // request
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   command,
    input  logic [COORD_W-1:0] x,
    input  logic [COORD_W-1:0] y,
    input  logic [COLOR_W-1:0] color,
    input  logic [ROP_W-1:0]   raster_op,
    input  logic [COORD_W-1:0] length,
    // result
    output logic               done,
    output logic [COLOR_W-1:0] pixel_color,
    output logic               status,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int ADDR_W = $clog2(PLANE_BYTES);
    localparam logic [OFF_W-1:0]  PLANE_LIMIT = OFF_W'(PLANE_BYTES);
    localparam logic [ADDR_W-1:0] CLR_LAST    = ADDR_W'(PLANE_BYTES - 1);

    // control registers
    state_t              state_reg, state_next;
    logic [LB_W-1:0]     line_bytes_reg, line_bytes_next;
    logic                done_reg, done_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;

    // request and working payload
    cmd_t                cmd_reg, cmd_next;
    logic [COORD_W-1:0]  x_reg, x_next;
    logic [COORD_W-1:0]  y_reg, y_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    rop_t                rop_reg, rop_next;
    logic [COORD_W-1:0]  len_reg, len_next;
    logic [PROD_W-1:0]   prod_first_reg, prod_first_next;
    logic [PROD_W-1:0]   prod_last_reg, prod_last_next;
    logic [COORD_W:0]    end_x_reg, end_x_next;
    logic [COORD_W:0]    cur_x_reg, cur_x_next;
    logic [COORD_W-1:0]  rows_reg, rows_next;
    logic [OFF_W-1:0]    cur_off_reg, cur_off_next;
    logic [COLOR_W-1:0]  pixel_color_reg, pixel_color_next;
    logic                status_reg, status_next;

    // RAM port
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;

    // datapath helpers
    logic [COORD_W:0]    y_last;
    logic [OFF_W-1:0]    first_off;
    logic [OFF_W-1:0]    last_off;
    logic [2:0]          lo_pix;
    logic [2:0]          hi_pix;
    logic                last_byte;
    logic [7:0]          mask;
    logic [2:0]          rd_sh;
    logic [COLOR_W-1:0]  rd_pix;
    logic                cfg_write;

    ppre_ram #(
        .WIDTH(WORD_W),
        .DEPTH(PLANE_BYTES)
    ) u_plane_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // APB register access
    assign cfg_write = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign prdata    = {{(32-LB_W){1'b0}}, line_bytes_reg};

    // Outputs
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign pixel_color = pixel_color_reg;
    assign status      = status_reg;

    // Offsets of the first and last byte of the request
    assign y_last    = {1'b0, y_reg} + {1'b0, len_reg} - (COORD_W+1)'(1);
    assign first_off = OFF_W'(prod_first_reg) + OFF_W'(x_reg[COORD_W-1:3]);
    always_comb
    begin
        case (cmd_reg)
            CMD_HSPAN: last_off = OFF_W'(prod_first_reg) + OFF_W'(end_x_reg[COORD_W:3]);
            CMD_VSPAN: last_off = OFF_W'(prod_last_reg) + OFF_W'(x_reg[COORD_W-1:3]);
            default:   last_off = first_off;
        endcase
    end

    // Pixel mask of the byte under work
    assign last_byte = (cur_x_reg[COORD_W:3] == end_x_reg[COORD_W:3]);
    assign lo_pix    = cur_x_reg[2:0];
    assign hi_pix    = last_byte ? end_x_reg[2:0] : 3'd7;
    always_comb
    begin
        if (cmd_reg == CMD_VSPAN)
        begin
            mask = 8'h80 >> x_reg[2:0];
        end
        else
        begin
            mask = (8'hFF >> lo_pix) & (8'hFF << (3'd7 - hi_pix));
        end
    end

    // Extract the four plane bits of a read pixel
    assign rd_sh = 3'd7 - x_reg[2:0];
    always_comb
    begin
        for (int n = 0; n < COLOR_W; n++)
        begin
            rd_pix[n] = ram_rdata[8*n + int'(rd_sh)];
        end
    end

    // Next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        line_bytes_next  = line_bytes_reg;
        done_next        = 1'b0;
        clr_cnt_next     = clr_cnt_reg;
        cmd_next         = cmd_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        color_next       = color_reg;
        rop_next         = rop_reg;
        len_next         = len_reg;
        prod_first_next  = prod_first_reg;
        prod_last_next   = prod_last_reg;
        end_x_next       = end_x_reg;
        cur_x_next       = cur_x_reg;
        rows_next        = rows_reg;
        cur_off_next     = cur_off_reg;
        pixel_color_next = pixel_color_reg;
        status_next      = status_reg;
        ram_we           = 1'b0;
        ram_addr         = cur_off_reg[ADDR_W-1:0];
        ram_wdata        = '0;

        if (cfg_write)
        begin
            line_bytes_next = pwdata[LB_W-1:0];
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero one word per cycle
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // Latch the request
                if (start)
                begin
                    cmd_next   = cmd_t'(command);
                    x_next     = x;
                    y_next     = y;
                    color_next = color;
                    rop_next   = rop_t'(raster_op);
                    len_next   = length;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // Row products for the first and last rows
                prod_first_next = PROD_W'(y_reg) * PROD_W'(line_bytes_reg);
                prod_last_next  = PROD_W'(y_last) * PROD_W'(line_bytes_reg);
                if (cmd_reg == CMD_HSPAN)
                begin
                    end_x_next = {1'b0, x_reg} + {1'b0, len_reg} - (COORD_W+1)'(1);
                end
                else
                begin
                    end_x_next = {1'b0, x_reg};
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // Drop empty spans, reject out-of-plane requests
                pixel_color_next = '0;
                status_next      = 1'b0;
                cur_off_next     = first_off;
                cur_x_next       = {1'b0, x_reg};
                rows_next        = len_reg - COORD_W'(1);
                if (cmd_reg[1] && (len_reg == '0))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (last_off >= PLANE_LIMIT)
                begin
                    status_next = 1'b1;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                // Read the plane word; data is back next cycle
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    pixel_color_next = rd_pix;
                    done_next        = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    // Write back the modified word and advance
                    ram_we    = 1'b1;
                    ram_wdata = apply_rop(ram_rdata, color_reg, rop_reg, mask);
                    if (cmd_reg == CMD_VSPAN)
                    begin
                        if (rows_reg == '0)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            rows_next    = rows_reg - COORD_W'(1);
                            cur_off_next = cur_off_reg + OFF_W'(line_bytes_reg);
                            state_next   = ST_RD;
                        end
                    end
                    else if (last_byte)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cur_x_next   = {cur_x_reg[COORD_W:3] + (COORD_W-2)'(1), 3'b000};
                        cur_off_next = cur_off_reg + OFF_W'(1);
                        state_next   = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            line_bytes_reg <= LINE_BYTES_RESET;
            done_reg       <= 1'b0;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            line_bytes_reg <= line_bytes_next;
            done_reg       <= done_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        x_reg           <= x_next;
        y_reg           <= y_next;
        color_reg       <= color_next;
        rop_reg         <= rop_next;
        len_reg         <= len_next;
        prod_first_reg  <= prod_first_next;
        prod_last_reg   <= prod_last_next;
        end_x_reg       <= end_x_next;
        cur_x_reg       <= cur_x_next;
        rows_reg        <= rows_next;
        cur_off_reg     <= cur_off_next;
        pixel_color_reg <= pixel_color_next;
        status_reg      <= status_next;
    end

endmodule

@@ sim/tb_planar_pixel_raster_engine.sv @@
// Testbench for the planar pixel raster engine: requests checked against a plane-store predictor.
`timescale 1ns / 100ps

module tb_planar_pixel_raster_engine;
    import ppre_pkg::*;

    localparam int PLANE_BYTES = 65536;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_PER_PHASE = 356;
    localparam logic [1:0] LINE_BYTES_ADDR = 2'd0;

    typedef struct {
        cmd_t               command;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        rop_t               raster_op;
        logic [COORD_W-1:0] length;
    } raster_req_t;

    typedef struct {
        logic [COLOR_W-1:0] pixel_color;
        logic               status;
    } raster_rsp_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic [ROP_W-1:0]   raster_op;
    logic [COORD_W-1:0] length;
    logic               done;
    logic [COLOR_W-1:0] pixel_color;
    logic               status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [1:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor state: one word per plane byte offset, planes in byte lanes
    logic [WORD_W-1:0]  plane_words [PLANE_BYTES];
    logic [LB_W-1:0]    line_bytes_cfg;
    raster_rsp_t        pending_results [$];

    int error_count = 0;
    int req_count = 0;
    int read_count = 0;
    int span_count = 0;
    int reject_count = 0;
    int setting_count = 0;
    int checked_count = 0;
    int cycle_count = 0;

    planar_pixel_raster_engine #(
        .PLANE_BYTES(PLANE_BYTES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .x          (x),
        .y          (y),
        .color      (color),
        .raster_op  (raster_op),
        .length     (length),
        .done       (done),
        .pixel_color(pixel_color),
        .status     (status),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Byte offset of a pixel within each plane
    function automatic longint unsigned byte_index(longint unsigned col, longint unsigned row);
        longint unsigned lb;
        lb = line_bytes_cfg;
        return row * lb + (col >> 3);
    endfunction

    // Combine one color into one pixel of all four planes
    function automatic void paint_pixel(longint unsigned idx, longint unsigned col,
                                        logic [COLOR_W-1:0] c, rop_t op);
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] pm;
        word = plane_words[idx];
        for (int n = 0; n < COLOR_W; n++)
        begin
            pm = 32'h80 >> col[2:0];
            pm = pm << (8 * n);
            case (op)
                ROP_WRITE: word = c[n] ? (word | pm) : (word & ~pm);
                ROP_XOR:   if (c[n]) word = word ^ pm;
                ROP_OR:    if (c[n]) word = word | pm;
                ROP_AND:   if (!c[n]) word = word & ~pm;
                default:   word = word;
            endcase
        end
        plane_words[idx] = word;
    endfunction

    // Apply one request to the predicted frame and return its result
    function automatic raster_rsp_t predict_raster(raster_req_t r);
        raster_rsp_t       rsp;
        longint unsigned   col0;
        longint unsigned   row0;
        longint unsigned   len;
        longint unsigned   idx;
        longint unsigned   last;
        logic [WORD_W-1:0] word;
        col0 = r.x;
        row0 = r.y;
        len = r.length;
        rsp.pixel_color = '0;
        rsp.status = 1'b0;
        if (r.command == CMD_READ || r.command == CMD_PIXEL)
        begin
            idx = byte_index(col0, row0);
            if (idx >= PLANE_BYTES)
                rsp.status = 1'b1;
            else if (r.command == CMD_READ)
            begin
                word = plane_words[idx];
                for (int n = 0; n < COLOR_W; n++)
                    rsp.pixel_color[n] = word[8 * n + 7 - r.x[2:0]];
            end
            else
                paint_pixel(idx, col0, r.color, r.raster_op);
        end
        else if (len != 0)
        begin
            // Check the span on its last byte before touching anything
            if (r.command == CMD_HSPAN)
                last = byte_index(col0 + len - 1, row0);
            else
                last = byte_index(col0, row0 + len - 1);
            if (last >= PLANE_BYTES)
                rsp.status = 1'b1;
            else if (r.command == CMD_HSPAN)
            begin
                for (longint unsigned i = 0; i < len; i++)
                    paint_pixel(byte_index(col0 + i, row0), col0 + i, r.color, r.raster_op);
            end
            else
            begin
                for (longint unsigned i = 0; i < len; i++)
                    paint_pixel(byte_index(col0, row0 + i), col0, r.color, r.raster_op);
            end
        end
        return rsp;
    endfunction

    function automatic raster_req_t request_of(cmd_t cmd, int col, int row, int c, rop_t op,
                                               int len);
        raster_req_t r;
        r.command = cmd;
        r.x = COORD_W'(col);
        r.y = COORD_W'(row);
        r.color = COLOR_W'(c);
        r.raster_op = op;
        r.length = COORD_W'(len);
        return r;
    endfunction

    // Mostly a small window so reads land on drawn pixels; sometimes the full range
    function automatic raster_req_t random_request();
        raster_req_t r;
        int          sel;
        r.command = cmd_t'($urandom_range(0, 3));
        r.color = COLOR_W'($urandom_range(0, 15));
        r.raster_op = rop_t'($urandom_range(0, 3));
        r.x = COORD_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                                    : $urandom_range(0, 127));
        r.y = COORD_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                                    : $urandom_range(0, 15));
        sel = $urandom_range(0, 19);
        case (r.command)
            CMD_HSPAN:
            begin
                if (sel == 0)
                    r.length = COORD_W'($urandom_range(0, 8191));
                else if (sel < 5)
                    r.length = COORD_W'($urandom_range(0, 200));
                else
                    r.length = COORD_W'($urandom_range(0, 24));
            end
            CMD_VSPAN:
            begin
                if (sel < 4)
                    r.length = COORD_W'($urandom_range(0, 120));
                else
                    r.length = COORD_W'($urandom_range(0, 24));
            end
            default:
                r.length = COORD_W'($urandom_range(0, 8191));
        endcase
        return r;
    endfunction

    // Drive one request and hold it until the block takes it
    task automatic send_request(input raster_req_t r);
        raster_rsp_t rsp;
        @(negedge clk);
        start = 1'b1;
        command = r.command;
        x = r.x;
        y = r.y;
        color = r.color;
        raster_op = r.raster_op;
        length = r.length;
        do
            @(posedge clk);
        while (busy);
        rsp = predict_raster(r);
        pending_results.push_back(rsp);
        req_count++;
        if (r.command == CMD_READ)
            read_count++;
        if (r.command == CMD_HSPAN || r.command == CMD_VSPAN)
            span_count++;
        if (rsp.status)
            reject_count++;
    endtask

    task automatic hold_off(input int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Drop start and wait until every expected result is in and the block is free
    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic apb_write(input logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = LINE_BYTES_ADDR;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apb_read(output logic [31:0] got);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = LINE_BYTES_ADDR;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Write line_bytes while idle, then read it back
    task automatic set_line_bytes(input logic [31:0] data);
        logic [31:0] got;
        wait_idle();
        apb_write(data);
        line_bytes_cfg = data[LB_W-1:0];
        setting_count++;
        apb_read(got);
        if (got != {21'b0, data[LB_W-1:0]})
        begin
            $error("line_bytes: expected %0d, got %0d", data[LB_W-1:0], got);
            error_count++;
        end
    endtask

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        raster_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending: pixel_color %0d, status %0d",
                       pixel_color, status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                if (pixel_color !== want.pixel_color)
                begin
                    $error("pixel_color: expected %0d, got %0d", want.pixel_color, pixel_color);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
            end
        end
    end

    task automatic test_reset_register();
        logic [31:0] got;
        wait_idle();
        apb_read(got);
        if (got != {21'b0, LINE_BYTES_RESET})
        begin
            $error("line_bytes: expected %0d, got %0d", LINE_BYTES_RESET, got);
            error_count++;
        end
    endtask

    // Single pixels: every op, cleared store, plane-edge reject
    task automatic test_pixel_ops();
        send_request(request_of(CMD_READ, 0, 0, 0, ROP_WRITE, 0));
        send_request(request_of(CMD_PIXEL, 0, 0, 15, ROP_WRITE, 0));
        send_request(request_of(CMD_READ, 0, 0, 0, ROP_WRITE, 8191));
        send_request(request_of(CMD_PIXEL, 0, 0, 6, ROP_AND, 0));
        send_request(request_of(CMD_PIXEL, 0, 0, 9, ROP_OR, 0));
        send_request(request_of(CMD_PIXEL, 0, 0, 5, ROP_XOR, 0));
        send_request(request_of(CMD_READ, 0, 0, 0, ROP_WRITE, 0));
        send_request(request_of(CMD_PIXEL, 8191, 8191, 15, ROP_WRITE, 0));
        send_request(request_of(CMD_READ, 8191, 0, 0, ROP_WRITE, 0));
        send_request(request_of(CMD_PIXEL, 7, 818, 3, ROP_WRITE, 0));
    endtask

    // Spans: zero length, wrap into the next line, rejects past the plane
    task automatic test_span_edges();
        send_request(request_of(CMD_HSPAN, 0, 2, 15, ROP_WRITE, 0));
        send_request(request_of(CMD_HSPAN, 632, 0, 5, ROP_XOR, 16));
        send_request(request_of(CMD_READ, 0, 1, 0, ROP_WRITE, 0));
        send_request(request_of(CMD_HSPAN, 0, 819, 15, ROP_WRITE, 8191));
        send_request(request_of(CMD_VSPAN, 3, 0, 10, ROP_OR, 819));
        send_request(request_of(CMD_VSPAN, 3, 1, 10, ROP_OR, 900));
        send_request(request_of(CMD_READ, 3, 818, 0, ROP_WRITE, 0));
    endtask

    // Register extremes: zero folds every row onto row 0, widest lines, max span
    task automatic test_line_bytes_extremes();
        set_line_bytes(32'd0);
        send_request(request_of(CMD_VSPAN, 9, 0, 15, ROP_XOR, 8191));
        send_request(request_of(CMD_READ, 9, 4000, 0, ROP_WRITE, 0));
        set_line_bytes(32'd2047);
        send_request(request_of(CMD_READ, 0, 32, 0, ROP_WRITE, 0));
        send_request(request_of(CMD_READ, 0, 33, 0, ROP_WRITE, 0));
        set_line_bytes(32'd1024);
        send_request(request_of(CMD_HSPAN, 0, 63, 12, ROP_WRITE, 8191));
        send_request(request_of(CMD_READ, 8191, 63, 0, ROP_WRITE, 0));
    endtask

    task automatic run_random_phase(input logic [31:0] lb, input int count, input bit with_gaps);
        bit gap_stretch;
        gap_stretch = 1'b0;
        set_line_bytes(lb);
        for (int i = 0; i < count; i++)
        begin
            // Switch idling on and off in stretches
            if (i % 40 == 0)
                gap_stretch = with_gaps && ($urandom_range(0, 1) == 1);
            // Pause until the pipeline drains once in each phase run with gaps
            if (with_gaps && i == count / 2)
                wait_idle();
            send_request(random_request());
            if (gap_stretch && $urandom_range(0, 2) == 0)
                hold_off($urandom_range(1, 16));
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(32'd1, RANDOM_PER_PHASE, 1'b1);
        run_random_phase(32'd1024, RANDOM_PER_PHASE, 1'b1);
        run_random_phase(32'd0, RANDOM_PER_PHASE, 1'b1);
        run_random_phase(32'd2047, RANDOM_PER_PHASE, 1'b1);
        // Upper data bits are not part of the register
        run_random_phase({21'($urandom_range(0, 2097151)), 11'(($urandom_range(1, 1024)))},
                         RANDOM_PER_PHASE, 1'b0);
    endtask

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_planar_pixel_raster_engine failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = '0;
        x = '0;
        y = '0;
        color = '0;
        raster_op = '0;
        length = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < PLANE_BYTES; i++)
            plane_words[i] = '0;
        line_bytes_cfg = LINE_BYTES_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_register();
        test_pixel_ops();
        test_span_edges();
        test_line_bytes_extremes();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d requests: %0d reads, %0d spans, %0d rejected past the plane",
                 req_count, read_count, span_count, reject_count);
        $display("Checked %0d results across %0d line_bytes settings",
                 checked_count, setting_count);
        if (error_count == 0)
            $display("tb_planar_pixel_raster_engine passed");
        else
            $display("tb_planar_pixel_raster_engine failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/ppre_pkg.sv
src/ppre_ram.sv
src/planar_pixel_raster_engine.sv
sim/tb_planar_pixel_raster_engine.sv
